[sv/bpe_pkg.sv]
// shared widths, codes and defaults for the bezier point evaluator
package bpe_pkg;

    localparam int COORD_W        = 24;
    localparam int T_W            = 17;
    localparam int ST_W           = 2;
    localparam int MAX_POINTS_DEF = 16;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_DROP  = 2'd2;

endpackage

[sv/bezier_point_evaluator.sv]
// de casteljau bezier evaluator over a stored control polygon
//
// Command port: an item is taken on a rising edge with start high and busy low.
// i_func selects load (append i_coord_x/i_coord_y, i_first restarts the polygon)
// or evaluate (i_t_param in Q1.16, values above 1.0 clamp to 1.0).
// A load gives no result and leaves busy low, so loads may come every cycle.
// An evaluate gives one result beat: o_valid high for one cycle with
// o_curve_x, o_curve_y and o_status. The receiver cannot hold a beat off.
// For an evaluate with n stored points:
//   n = 0 : result in the next cycle, status empty
//   n = 1 : the stored point is the result
//   n > 1 : levels L = n-1 .. 1 are run in turn
// Each level streams L+1 reads (polygon store for the first level, work memory
// after; one read port each), one interpolation per cycle per axis on a three-stage
// subtract, multiply, add pipe, then drains the pipe before the next level reads.
// Synchronous reset empties the polygon and clears the dropped flag;
// memory contents are not cleared.
module bezier_point_evaluator #(
    parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic                                i_first,
    input  logic signed [bpe_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [bpe_pkg::COORD_W-1:0]  i_coord_y,
    input  logic        [bpe_pkg::T_W-1:0]      i_t_param,
    output logic                                o_valid,
    output logic signed [bpe_pkg::COORD_W-1:0]  o_curve_x,
    output logic signed [bpe_pkg::COORD_W-1:0]  o_curve_y,
    output logic        [bpe_pkg::ST_W-1:0]     o_status
);
    import bpe_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 2 * COORD_W;
    localparam int DW = COORD_W + 1;
    localparam int MW = DW + T_W + 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state;

    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic [IW-1:0] r_level;
    logic [IW-1:0] r_rd_idx;
    logic          r_src_pt;
    logic [T_W-1:0] r_t;

    // polygon store and interpolation scratch, {x, y} packed
    logic [PW-1:0] r_pt_mem [MAX_POINTS];
    logic [PW-1:0] r_wk_mem [MAX_POINTS];
    logic [PW-1:0] r_pt_q;
    logic [PW-1:0] r_wk_q;

    logic          r_s1_vld;
    logic [IW-1:0] r_s1_idx;
    logic          r_s1_src;

    logic                 r_s2_vld;
    logic [IW-1:0]        r_s2_widx;
    logic signed [COORD_W-1:0] r_s2_a_x, r_s2_a_y;
    logic signed [DW-1:0] r_s2_d_x, r_s2_d_y;

    logic                 r_s3_vld;
    logic [IW-1:0]        r_s3_widx;
    logic signed [COORD_W-1:0] r_s3_a_x, r_s3_a_y;
    logic signed [MW-1:0] r_s3_p_x, r_s3_p_y;

    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_W-1:0] r_res_x, r_res_y;

    logic                      r_out_vld;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic [ST_W-1:0]           r_out_st;

    logic          acc;
    logic          ld_wr;
    logic [IW-1:0] ld_addr;
    logic [CW-1:0] cnt_m1;
    logic [PW-1:0] q;
    logic signed [COORD_W-1:0] q_x, q_y;
    logic signed [COORD_W-1:0] res_x, res_y;
    logic          pipe_empty;

    assign busy       = (r_state != S_IDLE);
    assign acc        = start && !busy;
    assign ld_wr      = acc && (i_func == FUNC_LOAD)
                        && (i_first || (r_count < CW'(MAX_POINTS)));
    assign ld_addr    = i_first ? '0 : r_count[IW-1:0];
    assign cnt_m1     = r_count - 1'b1;
    assign pipe_empty = !r_s1_vld && !r_s2_vld && !r_s3_vld;

    assign q   = r_s1_src ? r_pt_q : r_wk_q;
    assign q_x = q[PW-1:COORD_W];
    assign q_y = q[COORD_W-1:0];

    // the interpolated value lies between its neighbours, so 24-bit wrap is exact
    assign res_x = r_s3_a_x + r_s3_p_x[16 +: COORD_W];
    assign res_y = r_s3_a_y + r_s3_p_y[16 +: COORD_W];

    always_ff @(posedge i_clk) begin
        if (ld_wr) begin
            r_pt_mem[ld_addr] <= {i_coord_x, i_coord_y};
        end
        r_pt_q <= r_pt_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_wk_mem[r_s3_widx] <= {res_x, res_y};
        end
        r_wk_q <= r_wk_mem[r_rd_idx];
    end

    // interpolation pipe: neighbour difference, multiply by t, add back
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_prev_x  <= q_x;
            r_prev_y  <= q_y;
            r_s2_a_x  <= r_prev_x;
            r_s2_a_y  <= r_prev_y;
            r_s2_d_x  <= {q_x[COORD_W-1], q_x} - {r_prev_x[COORD_W-1], r_prev_x};
            r_s2_d_y  <= {q_y[COORD_W-1], q_y} - {r_prev_y[COORD_W-1], r_prev_y};
            r_s2_widx <= r_s1_idx - 1'b1;
            if (r_s1_idx == '0) begin
                r_res_x <= q_x;
                r_res_y <= q_y;
            end
        end
        r_s3_a_x  <= r_s2_a_x;
        r_s3_a_y  <= r_s2_a_y;
        r_s3_widx <= r_s2_widx;
        r_s3_p_x  <= MW'(r_s2_d_x) * $signed({1'b0, r_t});
        r_s3_p_y  <= MW'(r_s2_d_y) * $signed({1'b0, r_t});
        if (r_s3_vld) begin
            r_res_x <= res_x;
            r_res_y <= res_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_level   <= '0;
            r_rd_idx  <= '0;
            r_src_pt  <= 1'b0;
            r_t       <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_idx  <= '0;
            r_s1_src  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_out_x   <= '0;
            r_out_y   <= '0;
            r_out_st  <= ST_OK;
        end else begin
            r_out_vld <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= r_s1_vld && (r_s1_idx != '0);
            r_s3_vld  <= r_s2_vld;
            case (r_state)
                S_IDLE: begin
                    if (acc && (i_func == FUNC_LOAD)) begin
                        if (i_first) begin
                            r_count   <= CW'(1);
                            r_dropped <= 1'b0;
                        end else if (r_count < CW'(MAX_POINTS)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end else if (acc) begin
                        if (r_count == '0) begin
                            r_out_vld <= 1'b1;
                            r_out_x   <= '0;
                            r_out_y   <= '0;
                            r_out_st  <= ST_EMPTY;
                        end else begin
                            r_t      <= (i_t_param > T_ONE) ? T_ONE : i_t_param;
                            r_level  <= cnt_m1[IW-1:0];
                            r_rd_idx <= '0;
                            r_src_pt <= 1'b1;
                            r_state  <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_s1_vld <= 1'b1;
                    r_s1_idx <= r_rd_idx;
                    r_s1_src <= r_src_pt;
                    if (r_rd_idx == r_level) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // next level reads what this one wrote, so let the pipe empty
                    if (pipe_empty) begin
                        if (r_level <= IW'(1)) begin
                            r_out_vld <= 1'b1;
                            r_out_x   <= r_res_x;
                            r_out_y   <= r_res_y;
                            r_out_st  <= r_dropped ? ST_DROP : ST_OK;
                            r_state   <= S_IDLE;
                        end else begin
                            r_level  <= r_level - 1'b1;
                            r_rd_idx <= '0;
                            r_src_pt <= 1'b0;
                            r_state  <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_out_vld;
    assign o_curve_x = r_out_x;
    assign o_curve_y = r_out_y;
    assign o_status  = r_out_st;

endmodule

[sv/bpe_chk.sv]
// port-level checks for the bezier point evaluator, bound to the top level
module bpe_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                i_func,
    input logic                                o_valid,
    input logic signed [bpe_pkg::COORD_W-1:0]  o_curve_x,
    input logic signed [bpe_pkg::COORD_W-1:0]  o_curve_y,
    input logic        [bpe_pkg::ST_W-1:0]     o_status
);
    import bpe_pkg::*;

    // a load never occupies the block
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_LOAD)) |=> !busy)
        else $error("load left the block busy");

    // an evaluate either starts work or answers at once with an empty beat
    a_eval_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_EVAL)) |=> (busy || o_valid))
        else $error("evaluate neither started nor answered");

    // a result beat only follows work or a just accepted evaluate
    a_beat_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || ($past(start) && ($past(i_func) == FUNC_EVAL))))
        else $error("result beat without a cause");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> ((o_curve_x == '0) && (o_curve_y == '0)))
        else $error("empty status with a non-zero point");

endmodule

bind bezier_point_evaluator bpe_chk u_bpe_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_func    (i_func),
    .o_valid   (o_valid),
    .o_curve_x (o_curve_x),
    .o_curve_y (o_curve_y),
    .o_status  (o_status)
);
